[design/clcd_pkg.sv]
// Shared types, constants and the phase duration lookup for the character LCD controller.
// No dependencies.
`timescale 1ns / 1ps

package clcd_pkg;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned DUR_W = 20;

  typedef enum logic [3:0] {
    PH_PWR    = 4'd0,
    PH_EH1    = 4'd1,
    PH_EL1    = 4'd2,
    PH_EH2    = 4'd3,
    PH_EL2    = 4'd4,
    PH_SETTLE = 4'd5,
    PH_POST   = 4'd6,
    PH_IDLE   = 4'd7
  } phase_t;

  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_CHAR = 2'd1;
  localparam logic [1:0] FN_CMD  = 2'd2;
  localparam logic [1:0] FN_ADDR = 2'd3;

  localparam logic [2:0] REG_POWER_UP    = 3'd0;
  localparam logic [2:0] REG_ENABLE_HIGH = 3'd1;
  localparam logic [2:0] REG_ENABLE_LOW  = 3'd2;
  localparam logic [2:0] REG_SETTLE      = 3'd3;
  localparam logic [2:0] REG_CLEAR_WAIT  = 3'd4;
  localparam logic [2:0] REG_FUNC_SET    = 3'd5;
  localparam logic [2:0] REG_ENTRY_MODE  = 3'd6;
  localparam logic [2:0] REG_DISP_CTRL   = 3'd7;

  localparam logic [3:0] INIT_DONE = 4'd9;
  localparam logic [3:0] INIT_FIRST_BYTE = 4'd4;

  localparam logic [7:0] BYTE_WAKE      = 8'h30;
  localparam logic [7:0] BYTE_FOUR_BIT  = 8'h20;
  localparam logic [7:0] BYTE_DISP_OFF  = 8'h08;
  localparam logic [7:0] BYTE_CLEAR     = 8'h01;
  localparam logic [7:0] BYTE_HOME      = 8'h02;
  localparam logic [7:0] ADDR_CMD_BIT   = 8'h80;

  localparam logic [DUR_W-1:0] WAIT_FIRST_WAKE = 20'd10000;
  localparam logic [DUR_W-1:0] WAIT_WAKE       = 20'd500;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic       pin_rs;
    logic       pin_rw;
    logic       pin_enable;
    logic [3:0] pin_nibble;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [19:0] power_up_ticks;
    logic [7:0]  enable_high_ticks;
    logic [7:0]  enable_low_ticks;
    logic [9:0]  settle_ticks;
    logic [15:0] clear_wait_ticks;
    logic [7:0]  function_set_cmd;
    logic [7:0]  entry_mode_cmd;
    logic [7:0]  display_ctrl_cmd;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] step;
    logic [7:0] byte_val;
    logic       rs;
    logic       en;
    logic [3:0] nib;
  } seq_state_t;

  function automatic logic [DUR_W-1:0] phase_len(input seq_state_t s, input cfg_t c);
    logic [DUR_W-1:0] d;
    d = '0;
    case (s.phase)
      PH_PWR:            d = c.power_up_ticks;
      PH_EH1, PH_EH2:    d = DUR_W'(c.enable_high_ticks);
      PH_EL1, PH_EL2:    d = DUR_W'(c.enable_low_ticks);
      PH_SETTLE:         d = DUR_W'(c.settle_ticks);
      PH_POST: begin
        if (s.step == 4'd0) begin
          d = WAIT_FIRST_WAKE;
        end else if (s.step == 4'd1 || s.step == 4'd2) begin
          d = WAIT_WAKE;
        end else if (s.step == 4'd3) begin
          d = '0;
        end else if (!s.rs && (s.byte_val == BYTE_CLEAR || s.byte_val == BYTE_HOME)) begin
          d = DUR_W'(c.clear_wait_ticks);
        end else begin
          d = '0;
        end
      end
      default:           d = '0;
    endcase
    return d;
  endfunction

endpackage

[design/clcd_adv.sv]
// Phase sequencer step: moves the bus state to the phase that follows the current one.
// Depends on clcd_pkg for the state, configuration and phase types.
`timescale 1ns / 1ps

module clcd_adv (
  input  clcd_pkg::seq_state_t cur,
  input  clcd_pkg::cfg_t       cfg,
  output clcd_pkg::seq_state_t nxt
);
  import clcd_pkg::*;

  function automatic logic [7:0] init_byte(input logic [3:0] step, input cfg_t c);
    logic [7:0] b;
    b = c.display_ctrl_cmd;
    case (step)
      4'd0, 4'd1, 4'd2: b = BYTE_WAKE;
      4'd3:             b = BYTE_FOUR_BIT;
      4'd4:             b = c.function_set_cmd;
      4'd5:             b = BYTE_DISP_OFF;
      4'd6:             b = BYTE_CLEAR;
      4'd7:             b = c.entry_mode_cmd;
      default:          b = c.display_ctrl_cmd;
    endcase
    return b;
  endfunction

  function automatic seq_state_t start_init(input seq_state_t s, input logic [3:0] step,
                                            input cfg_t c);
    seq_state_t r;
    r = s;
    r.step = step;
    r.rs = 1'b0;
    r.byte_val = init_byte(step, c);
    r.phase = PH_EH1;
    r.en = 1'b1;
    r.nib = r.byte_val[7:4];
    return r;
  endfunction

  function automatic seq_state_t go_idle(input seq_state_t s);
    seq_state_t r;
    r = s;
    r.step = INIT_DONE;
    r.rs = 1'b0;
    r.phase = PH_IDLE;
    r.en = 1'b0;
    return r;
  endfunction

  logic [3:0] step_inc;

  assign step_inc = cur.step + 4'd1;

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_PWR: nxt = start_init(cur, 4'd0, cfg);
      PH_EH1: begin
        nxt.phase = PH_EL1;
        nxt.en = 1'b0;
      end
      PH_EL1: begin
        if (cur.step < INIT_FIRST_BYTE) begin
          nxt.phase = PH_POST;
          nxt.en = 1'b0;
        end else begin
          nxt.phase = PH_EH2;
          nxt.en = 1'b1;
          nxt.nib = cur.byte_val[3:0];
        end
      end
      PH_EH2: begin
        nxt.phase = PH_EL2;
        nxt.en = 1'b0;
      end
      PH_EL2: begin
        nxt.phase = PH_SETTLE;
        nxt.en = 1'b0;
      end
      PH_SETTLE: begin
        nxt.phase = PH_POST;
        nxt.en = 1'b0;
        nxt.nib = 4'd0;
      end
      PH_POST: begin
        if (cur.step < INIT_DONE && step_inc < INIT_DONE) begin
          nxt = start_init(cur, step_inc, cfg);
        end else begin
          nxt = go_idle(cur);
        end
      end
      default: nxt = go_idle(cur);
    endcase
  end

endmodule

[design/char_lcd_nibble_interface_top.sv]
// Top level of the 4-bit character LCD controller: item handling, timers, result register.
// Depends on clcd_pkg and clcd_adv.
`timescale 1ns / 1ps

// Each input beat is a one-microsecond tick or a request; each accepted beat gives one result
// beat carrying the bus pin levels, busy and rejected. A beat is taken every cycle while the
// result output is not stalled and no phase pass is pending, and its result is registered in
// the result register. When a beat leads into phases of zero duration, the single phase-advance
// unit passes one such phase per cycle and in_ready stays low until a phase of nonzero duration
// or idle is reached. Configuration registers are written through the cfg port with index 0
// to 7 in the documented order.
module char_lcd_nibble_interface_top #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  clcd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output clcd_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import clcd_pkg::*;

  localparam int unsigned LW = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
  localparam logic [LW-1:0] TMAX_W = LW'({TIMER_BITS{1'b1}});

  cfg_t                  cfg_r;
  seq_state_t            st_r, st_nxt, st_adv, st_req;
  logic [TIMER_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic             accept, is_tick, is_idle, tick_fire, req_take, req_rej, fired, produce;
  logic [LW-1:0]    len_cur, len_nxt;

  clcd_adv u_adv (
    .cur (st_r),
    .cfg (cfg_r),
    .nxt (st_adv)
  );

  function automatic logic [LW-1:0] clamp_len(input logic [DUR_W-1:0] d);
    logic [LW-1:0] w;
    w = LW'(d);
    return (w > TMAX_W) ? TMAX_W : w;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = !pend_r && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign is_tick   = (in_data.func == FN_TICK);
  assign is_idle   = (st_r.phase == PH_IDLE);
  assign cnt_inc   = (cnt_r == {TIMER_BITS{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign len_cur   = clamp_len(phase_len(st_r, cfg_r));
  assign tick_fire = accept && is_tick && !is_idle && (LW'(cnt_inc) >= len_cur);
  assign req_take  = accept && !is_tick && is_idle;
  assign req_rej   = accept && !is_tick && !is_idle;
  assign fired     = tick_fire || req_take || pend_r;

  always_comb begin
    st_req = st_r;
    st_req.rs = (in_data.func == FN_CHAR);
    st_req.byte_val = (in_data.func == FN_ADDR) ? (in_data.value | ADDR_CMD_BIT)
                                                : in_data.value;
    st_req.step = INIT_DONE;
    st_req.phase = PH_EH1;
    st_req.en = 1'b1;
    st_req.nib = st_req.byte_val[7:4];
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    if (req_take) begin
      st_nxt = st_req;
      cnt_nxt = '0;
    end else if (tick_fire || pend_r) begin
      st_nxt = st_adv;
      cnt_nxt = '0;
    end else if (accept && is_tick && !is_idle) begin
      cnt_nxt = cnt_inc;
    end
  end

  assign len_nxt  = clamp_len(phase_len(st_nxt, cfg_r));
  assign pend_nxt = fired && (st_nxt.phase != PH_IDLE) && (len_nxt == '0);
  assign produce  = (accept || pend_r) && !pend_nxt;

  always_comb begin
    out_data_nxt.pin_rs     = st_nxt.rs;
    out_data_nxt.pin_rw     = 1'b0;
    out_data_nxt.pin_enable = st_nxt.en;
    out_data_nxt.pin_nibble = st_nxt.nib;
    out_data_nxt.busy_res   = (st_nxt.phase != PH_IDLE);
    out_data_nxt.rejected   = req_rej;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_up_ticks    <= 20'd800000;
      cfg_r.enable_high_ticks <= 8'd15;
      cfg_r.enable_low_ticks  <= 8'd5;
      cfg_r.settle_ticks      <= 10'd100;
      cfg_r.clear_wait_ticks  <= 16'd5000;
      cfg_r.function_set_cmd  <= 8'h2c;
      cfg_r.entry_mode_cmd    <= 8'h06;
      cfg_r.display_ctrl_cmd  <= 8'h0c;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POWER_UP:    cfg_r.power_up_ticks    <= cfg_data;
        REG_ENABLE_HIGH: cfg_r.enable_high_ticks <= cfg_data[7:0];
        REG_ENABLE_LOW:  cfg_r.enable_low_ticks  <= cfg_data[7:0];
        REG_SETTLE:      cfg_r.settle_ticks      <= cfg_data[9:0];
        REG_CLEAR_WAIT:  cfg_r.clear_wait_ticks  <= cfg_data[15:0];
        REG_FUNC_SET:    cfg_r.function_set_cmd  <= cfg_data[7:0];
        REG_ENTRY_MODE:  cfg_r.entry_mode_cmd    <= cfg_data[7:0];
        REG_DISP_CTRL:   cfg_r.display_ctrl_cmd  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= PH_PWR;
      st_r.step     <= 4'd0;
      st_r.byte_val <= 8'd0;
      st_r.rs       <= 1'b0;
      st_r.en       <= 1'b0;
      st_r.nib      <= 4'd0;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_strobe_low: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (!st_r.en && !st_r.rs && cnt_r == '0))
    else $error("idle with strobe, RS or timer active");

  a_pend_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (st_r.phase != PH_IDLE && !out_valid_r))
    else $error("phase pass pending while idle or with a result waiting");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    req_rej |=> $stable(st_r))
    else $error("rejected request changed the bus state");

  a_result_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.busy_res) |-> (!out_data_r.pin_enable && !out_data_r.pin_rw))
    else $error("idle result with strobe or read line high");

endmodule

[test/tb_top.sv]
// Self-checking testbench for char_lcd_nibble_interface_top: a scoreboard class predicts the
// pin levels of every result beat, and plain tasks drive ticks, requests and register writes.
// Depends on clcd_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_top;
  import clcd_pkg::*;

  localparam int unsigned TIMER_BITS = 20;
  localparam longint unsigned TICK_MAX = (64'd1 << TIMER_BITS) - 1;

  class lcd_bus_scoreboard;
    cfg_t              regs;
    phase_t            phase;
    logic [3:0]        step;
    logic [7:0]        latched;
    logic              rs;
    logic              en;
    logic [3:0]        nib;
    longint unsigned   elapsed;
    out_item_t         expected_pins[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      regs.power_up_ticks    = 20'd800000;
      regs.enable_high_ticks = 8'd15;
      regs.enable_low_ticks  = 8'd5;
      regs.settle_ticks      = 10'd100;
      regs.clear_wait_ticks  = 16'd5000;
      regs.function_set_cmd  = 8'h2c;
      regs.entry_mode_cmd    = 8'h06;
      regs.display_ctrl_cmd  = 8'h0c;
      phase   = PH_PWR;
      step    = 4'd0;
      latched = 8'h00;
      rs      = 1'b0;
      en      = 1'b0;
      nib     = 4'h0;
      elapsed = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_POWER_UP:    regs.power_up_ticks    = d[19:0];
        REG_ENABLE_HIGH: regs.enable_high_ticks = d[7:0];
        REG_ENABLE_LOW:  regs.enable_low_ticks  = d[7:0];
        REG_SETTLE:      regs.settle_ticks      = d[9:0];
        REG_CLEAR_WAIT:  regs.clear_wait_ticks  = d[15:0];
        REG_FUNC_SET:    regs.function_set_cmd  = d[7:0];
        REG_ENTRY_MODE:  regs.entry_mode_cmd    = d[7:0];
        REG_DISP_CTRL:   regs.display_ctrl_cmd  = d[7:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int unsigned outstanding();
      return expected_pins.size();
    endfunction

    function longint unsigned phase_ticks();
      longint unsigned d;
      case (phase)
        PH_PWR:         d = regs.power_up_ticks;
        PH_EH1, PH_EH2: d = regs.enable_high_ticks;
        PH_EL1, PH_EL2: d = regs.enable_low_ticks;
        PH_SETTLE:      d = regs.settle_ticks;
        PH_POST: begin
          if (step == 4'd0) begin
            d = WAIT_FIRST_WAKE;
          end else if (step == 4'd1 || step == 4'd2) begin
            d = WAIT_WAKE;
          end else if (step == 4'd3) begin
            d = 0;
          end else if (!rs && (latched == BYTE_CLEAR || latched == BYTE_HOME)) begin
            d = regs.clear_wait_ticks;
          end else begin
            d = 0;
          end
        end
        default: d = 0;
      endcase
      if (d > TICK_MAX) d = TICK_MAX;
      return d;
    endfunction

    function void go(phase_t ph, logic e, logic [3:0] n);
      phase   = ph;
      en      = e;
      nib     = n;
      elapsed = 0;
    endfunction

    function void launch_init_byte();
      logic [7:0] b;
      case (step)
        4'd0, 4'd1, 4'd2: b = BYTE_WAKE;
        4'd3:             b = BYTE_FOUR_BIT;
        4'd4:             b = regs.function_set_cmd;
        4'd5:             b = BYTE_DISP_OFF;
        4'd6:             b = BYTE_CLEAR;
        4'd7:             b = regs.entry_mode_cmd;
        default:          b = regs.display_ctrl_cmd;
      endcase
      rs      = 1'b0;
      latched = b;
      go(PH_EH1, 1'b1, b[7:4]);
    endfunction

    function void finish_transfer();
      step = INIT_DONE;
      rs   = 1'b0;
      go(PH_IDLE, 1'b0, nib);
    endfunction

    function void next_phase();
      case (phase)
        PH_PWR: begin
          step = 4'd0;
          launch_init_byte();
        end
        PH_EH1: go(PH_EL1, 1'b0, nib);
        PH_EL1: begin
          if (step < INIT_FIRST_BYTE) go(PH_POST, 1'b0, nib);
          else go(PH_EH2, 1'b1, latched[3:0]);
        end
        PH_EH2:    go(PH_EL2, 1'b0, nib);
        PH_EL2:    go(PH_SETTLE, 1'b0, nib);
        PH_SETTLE: go(PH_POST, 1'b0, 4'h0);
        PH_POST: begin
          if (step < INIT_DONE) step = step + 4'd1;
          if (step < INIT_DONE) launch_init_byte();
          else finish_transfer();
        end
        default: finish_transfer();
      endcase
    endfunction

    function void skip_empty();
      while (phase != PH_IDLE && phase_ticks() == 0) next_phase();
    endfunction

    function out_item_t predict_pins(in_item_t it);
      out_item_t o;
      logic      drop;
      drop = 1'b0;
      if (it.func == FN_TICK) begin
        if (phase != PH_IDLE) begin
          if (elapsed < TICK_MAX) elapsed++;
          if (elapsed >= phase_ticks()) begin
            next_phase();
            skip_empty();
          end
        end
      end else if (phase != PH_IDLE) begin
        drop = 1'b1;
      end else begin
        rs      = (it.func == FN_CHAR);
        latched = (it.func == FN_ADDR) ? (it.value | ADDR_CMD_BIT) : it.value;
        step    = INIT_DONE;
        go(PH_EH1, 1'b1, latched[7:4]);
        skip_empty();
      end
      o.pin_rs     = rs;
      o.pin_rw     = 1'b0;
      o.pin_enable = en;
      o.pin_nibble = nib;
      o.busy_res   = (phase != PH_IDLE);
      o.rejected   = drop;
      return o;
    endfunction

    function void note_input(in_item_t it);
      expected_pins.push_back(predict_pins(it));
    endfunction

    function void check_pins(out_item_t got);
      out_item_t exp_pins;
      if (expected_pins.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat %0d arrived with nothing expected", checked);
        return;
      end
      exp_pins = expected_pins.pop_front();
      if (got.pin_rs !== exp_pins.pin_rs || got.pin_rw !== exp_pins.pin_rw ||
          got.pin_enable !== exp_pins.pin_enable || got.pin_nibble !== exp_pins.pin_nibble ||
          got.busy_res !== exp_pins.busy_res || got.rejected !== exp_pins.rejected) begin
        errors++;
        if (errors <= 10) begin
          $display("beat %0d: expected rs=%b rw=%b e=%b d=%h busy=%b rej=%b", checked,
                   exp_pins.pin_rs, exp_pins.pin_rw, exp_pins.pin_enable,
                   exp_pins.pin_nibble, exp_pins.busy_res, exp_pins.rejected);
          $display("beat %0d: actual   rs=%b rw=%b e=%b d=%h busy=%b rej=%b", checked,
                   got.pin_rs, got.pin_rw, got.pin_enable, got.pin_nibble,
                   got.busy_res, got.rejected);
        end
      end
      checked++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lcd_bus_scoreboard sb = new();
  int unsigned       sent = 0;
  bit                calm_input = 1'b0;

  char_lcd_nibble_interface_top #(
    .TIMER_BITS(TIMER_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [7:0] v);
    in_item_t    it;
    int unsigned g;
    it.func  = f;
    it.value = v;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    sent++;
    if (sent % 96 == 0) calm_input = ($urandom_range(0, 2) == 0);
    g = calm_input ? 0 : pick_pause();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(FN_TICK, 8'($urandom));
  endtask

  task automatic send_random_request();
    logic [1:0] f;
    logic [7:0] v;
    f = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) v = ($urandom_range(0, 1) == 0) ? BYTE_CLEAR : BYTE_HOME;
    else v = 8'($urandom);
    send_item(f, v);
  endtask

  task automatic tick_until_idle();
    while (sb.busy()) begin
      if ($urandom_range(0, 33) == 0) send_random_request();
      else send_tick();
    end
  endtask

  task automatic probe(input logic [1:0] f, input logic [7:0] v);
    send_item(f, v);
    tick_until_idle();
  endtask

  task automatic random_traffic(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (!sb.busy()) begin
        if ($urandom_range(0, 99) < 45) send_random_request();
        else send_tick();
      end else begin
        if ($urandom_range(0, 99) < 6) send_random_request();
        else send_tick();
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] d);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [7:0] hi, input logic [7:0] lo,
                            input logic [9:0] st, input logic [15:0] cw);
    write_reg(REG_ENABLE_HIGH, {12'($urandom), hi});
    write_reg(REG_ENABLE_LOW, {12'($urandom), lo});
    write_reg(REG_SETTLE, {10'($urandom), st});
    write_reg(REG_CLEAR_WAIT, {4'($urandom), cw});
  endtask

  task automatic set_commands(input logic [7:0] fs, input logic [7:0] em, input logic [7:0] dc);
    write_reg(REG_FUNC_SET, {12'($urandom), fs});
    write_reg(REG_ENTRY_MODE, {12'($urandom), em});
    write_reg(REG_DISP_CTRL, {12'($urandom), dc});
  endtask

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_pins(out_data);
    end
  end

  initial begin : result_pacing
    int unsigned stall;
    int unsigned run;
    bit          held;
    bit          calm_output;
    held        = 1'b0;
    calm_output = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sb.checked >= 3000) begin
        held  = 1'b1;
        stall = 400;
      end else if (calm_output) begin
        stall = 0;
      end else begin
        stall = pick_pause();
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      if ($urandom_range(0, 63) == 0) calm_output = ~calm_output;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Init runs with a clear-style wait on the entry mode byte and extreme command bytes.
    write_reg(REG_POWER_UP, 20'hFFFFF);
    set_timing(8'd2, 8'd1, 10'd0, 16'd3);
    set_commands(8'h00, BYTE_HOME, 8'hFF);
    random_traffic(20);
    write_reg(REG_POWER_UP, 20'd0);
    tick_until_idle();

    set_timing(8'd1, 8'd1, 10'd0, 16'd0);
    send_item(FN_TICK, 8'hFF);
    send_item(FN_CHAR, 8'h00);
    send_item(FN_CMD, 8'h55);
    tick_until_idle();
    probe(FN_CHAR, 8'hFF);
    probe(FN_CMD, BYTE_CLEAR);
    probe(FN_CMD, BYTE_HOME);
    probe(FN_ADDR, 8'h7F);
    probe(FN_ADDR, 8'hFF);
    probe(FN_ADDR, 8'h00);
    probe(FN_CMD, 8'h00);

    set_timing(8'd255, 8'd255, 10'd1023, 16'd65535);
    set_commands(8'hFF, 8'h00, 8'h00);
    probe(FN_CHAR, 8'($urandom));
    send_item(FN_CMD, BYTE_HOME);
    for (int i = 0; i < 300; i++) send_tick();

    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        set_timing(8'd1, 8'd1, 10'd0, 16'd0);
      end else begin
        set_timing(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
                   ($urandom_range(0, 1) == 0) ? 10'd0 : 10'($urandom_range(1, 8)),
                   ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
      end
      if (p % 2 == 1) set_commands(8'($urandom), 8'($urandom), 8'($urandom));
      write_reg(REG_POWER_UP, 20'($urandom));
      random_traffic(120);
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
design/clcd_pkg.sv
design/clcd_adv.sv
design/char_lcd_nibble_interface_top.sv
test/tb_top.sv
